// ----- hdl/lepd_pkg.sv -----
// Shared constants and types for the express-scan packet decoder.
`timescale 1ns / 1ps
`default_nettype none
package lepd_pkg;

	localparam int PKT_LEN      = 84;
	localparam int HDR_LEN      = 4;
	localparam int CABIN_BYTES  = 5;
	localparam int NUM_CABINS   = 16;
	localparam int POS_W        = $clog2(PKT_LEN);
	localparam int CABIN_W      = $clog2(NUM_CABINS);
	localparam int CBYTE_W      = $clog2(CABIN_BYTES);

	localparam int BYTE_W       = 8;
	localparam int ANGLE_W      = 15;
	localparam int DIST_W       = 14;
	localparam int STATUS_W     = 2;

	localparam logic [ANGLE_W:0] FULL_TURN_Q6 = 16'd23040;
	localparam logic [3:0]       SYNC0_NIB    = 4'hA;
	localparam logic [3:0]       SYNC1_NIB    = 4'h5;

	localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_BAD_SYNC = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_BAD_SUM  = 2'd2;

	typedef struct packed {
		logic [ANGLE_W-1:0]  angle_q6;
		logic [DIST_W-1:0]   distance_q2;
		logic                scan_start;
		logic [STATUS_W-1:0] status;
		logic                last;
	} point_t;

	// controller -> datapath
	typedef struct packed {
		logic               take;        // byte beat accepted
		logic               check;       // verify header, load error result, rewind reader
		logic               rd;          // read one cabin byte from the store
		logic [CBYTE_W-1:0] rd_idx;      // byte slot within the cabin
		logic               ld_p1;       // load first point of the cabin
		logic               ld_p2;       // load second point of the cabin
		logic               next_cabin;
	} lepd_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic pkt_end;     // current byte position is the final one
		logic pkt_ok;      // sync and checksum good
		logic last_cabin;
	} lepd_sts_t;

endpackage
`default_nettype wire

// ----- hdl/lepd_byte_if.sv -----
// Byte input channel: valid/ready handshake with one received byte.
`timescale 1ns / 1ps
`default_nettype none
interface lepd_byte_if;
	import lepd_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

// ----- hdl/lepd_point_if.sv -----
// Result channel: valid/ready handshake with one decoded point or status.
`timescale 1ns / 1ps
`default_nettype none
interface lepd_point_if;
	import lepd_pkg::*;

	logic                valid;
	logic                ready;
	logic [ANGLE_W-1:0]  angle_q6;
	logic [DIST_W-1:0]   distance_q2;
	logic                scan_start;
	logic [STATUS_W-1:0] status;
	logic                last;

	modport source (output valid, output angle_q6, output distance_q2, output scan_start,
		output status, output last, input ready);
	modport sink   (input valid, input angle_q6, input distance_q2, input scan_start,
		input status, input last, output ready);
endinterface
`default_nettype wire

// ----- hdl/lepd_ctrl.sv -----
// Sequencer: byte collection, header check, cabin reads and result beats.
`timescale 1ns / 1ps
`default_nettype none
module lepd_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	input  wire lepd_pkg::lepd_sts_t  sts,
	output lepd_pkg::lepd_cmd_t       cmd
);
	import lepd_pkg::*;

	typedef enum logic [2:0] {
		COLLECT,
		CHECK,
		ERR_OUT,
		READ,
		CALC,
		EMIT1,
		EMIT2
	} state_t;

	state_t             state_q;
	logic [CBYTE_W-1:0] rd_cnt_q;

	localparam logic [CBYTE_W-1:0] LAST_SLOT = CBYTE_W'(CABIN_BYTES - 1);

	assign in_ready  = (state_q == COLLECT);
	assign out_valid = (state_q == ERR_OUT) || (state_q == EMIT1) || (state_q == EMIT2);

	always_comb begin
		cmd            = '0;
		cmd.take       = (state_q == COLLECT) && in_valid;
		cmd.check      = (state_q == CHECK);
		cmd.rd         = (state_q == READ);
		cmd.rd_idx     = rd_cnt_q;
		cmd.ld_p1      = (state_q == CALC);
		cmd.ld_p2      = (state_q == EMIT1) && out_ready;
		cmd.next_cabin = (state_q == EMIT2) && out_ready && !sts.last_cabin;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= COLLECT;
			rd_cnt_q <= '0;
		end else begin
			unique case (state_q)
				COLLECT: begin
					if (in_valid && sts.pkt_end) state_q <= CHECK;
				end
				CHECK: begin
					rd_cnt_q <= '0;
					state_q  <= sts.pkt_ok ? READ : ERR_OUT;
				end
				ERR_OUT: begin
					if (out_ready) state_q <= COLLECT;
				end
				READ: begin
					if (rd_cnt_q == LAST_SLOT) begin
						rd_cnt_q <= '0;
						state_q  <= CALC;
					end else begin
						rd_cnt_q <= rd_cnt_q + 1'b1;
					end
				end
				CALC: begin
					state_q <= EMIT1;
				end
				EMIT1: begin
					if (out_ready) state_q <= EMIT2;
				end
				EMIT2: begin
					if (out_ready) state_q <= sts.last_cabin ? COLLECT : READ;
				end
				default: state_q <= COLLECT;
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- hdl/lepd_dpath.sv -----
// Datapath: packet store, header registers, running XOR, point decode.
`timescale 1ns / 1ps
`default_nettype none
module lepd_dpath (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic [7:0]           rx_byte,
	input  wire lepd_pkg::lepd_cmd_t  cmd,
	output lepd_pkg::lepd_sts_t       sts,
	output lepd_pkg::point_t          result
);
	import lepd_pkg::*;

	localparam logic [POS_W-1:0] POS_LAST  = POS_W'(PKT_LEN - 1);
	localparam logic [POS_W-1:0] POS_CABIN = POS_W'(HDR_LEN);
	localparam logic [POS_W-1:0] POS_XOR   = POS_W'(2);
	localparam logic [CABIN_W-1:0] CABIN_LAST = CABIN_W'(NUM_CABINS - 1);

	logic [BYTE_W-1:0]  mem [PKT_LEN];
	logic [BYTE_W-1:0]  hdr_q [HDR_LEN];
	logic [BYTE_W-1:0]  cab_q [CABIN_BYTES];
	logic [POS_W-1:0]   pos_q;
	logic [POS_W-1:0]   rd_addr_q;
	logic [CABIN_W-1:0] cabin_q;
	logic [BYTE_W-1:0]  xor_q;
	point_t             result_q;

	logic                sync_ok;
	logic [BYTE_W-1:0]   hdr_sum;
	logic [ANGLE_W-1:0]  base;
	logic [5:0]          delta1;
	logic [5:0]          delta2;
	logic [ANGLE_W-1:0]  angle1;
	logic [ANGLE_W-1:0]  angle2;

	function automatic logic [ANGLE_W-1:0] wrap_angle(input logic [ANGLE_W-1:0] b,
		input logic [5:0] d);
		logic [ANGLE_W:0] sum;
		begin
			sum = {1'b0, b} + {(ANGLE_W - 8)'(0), d, 3'b000};
			if (sum >= FULL_TURN_Q6) sum = sum - FULL_TURN_Q6;
			return sum[ANGLE_W-1:0];
		end
	endfunction

	assign sync_ok = (hdr_q[0][7:4] == SYNC0_NIB) && (hdr_q[1][7:4] == SYNC1_NIB);
	assign hdr_sum = {hdr_q[1][3:0], hdr_q[0][3:0]};
	assign base    = {hdr_q[3][6:0], hdr_q[2]};
	assign delta1  = {cab_q[0][1:0], cab_q[4][3:0]};
	assign delta2  = {cab_q[2][1:0], cab_q[4][7:4]};
	assign angle1  = wrap_angle(base, delta1);
	assign angle2  = wrap_angle(base, delta2);

	assign sts.pkt_end    = (pos_q == POS_LAST);
	assign sts.pkt_ok     = sync_ok && (hdr_sum == xor_q);
	assign sts.last_cabin = (cabin_q == CABIN_LAST);
	assign result         = result_q;

	// packet store: one write, one registered read into the cabin slots
	always_ff @(posedge clk) begin
		if (cmd.take) mem[pos_q] <= rx_byte;
		if (cmd.rd) cab_q[cmd.rd_idx] <= mem[rd_addr_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.take && (pos_q < POS_CABIN)) hdr_q[pos_q[1:0]] <= rx_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			xor_q     <= '0;
			rd_addr_q <= POS_CABIN;
			cabin_q   <= '0;
		end else begin
			if (cmd.take) begin
				pos_q <= (pos_q == POS_LAST) ? '0 : pos_q + 1'b1;
				if (pos_q >= POS_XOR) xor_q <= xor_q ^ rx_byte;
			end
			if (cmd.check) begin
				xor_q     <= '0;
				rd_addr_q <= POS_CABIN;
				cabin_q   <= '0;
			end
			if (cmd.rd) rd_addr_q <= rd_addr_q + 1'b1;
			if (cmd.next_cabin) cabin_q <= cabin_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		priority if (cmd.check) begin
			result_q.angle_q6    <= '0;
			result_q.distance_q2 <= '0;
			result_q.scan_start  <= 1'b0;
			result_q.status      <= sync_ok ? STATUS_BAD_SUM : STATUS_BAD_SYNC;
			result_q.last        <= 1'b1;
		end else if (cmd.ld_p1) begin
			result_q.angle_q6    <= angle1;
			result_q.distance_q2 <= {cab_q[1], cab_q[0][7:2]};
			result_q.scan_start  <= hdr_q[3][7] && (cabin_q == '0);
			result_q.status      <= STATUS_OK;
			result_q.last        <= 1'b0;
		end else if (cmd.ld_p2) begin
			result_q.angle_q6    <= angle2;
			result_q.distance_q2 <= {cab_q[3], cab_q[2][7:2]};
			result_q.scan_start  <= 1'b0;
			result_q.status      <= STATUS_OK;
			result_q.last        <= (cabin_q == CABIN_LAST);
		end else begin
			result_q <= result_q;
		end
	end

endmodule
`default_nettype wire

// ----- hdl/lidar_express_packet_decoder_top.sv -----
// Top level of the express-scan packet decoder.
//
//   channel  dir  payload                                           beat
//   rx       in   rx_byte[7:0]                                      one received byte
//   points   out  angle_q6, distance_q2, scan_start, status, last   one point or status
//
// A byte is taken when rx is valid and ready; bytes 1..83 of a packet cause no result.
// In the cycle after byte 84 the CHECK state checks the header; a bad packet then gives one status beat.
// A good packet gives 16 cabins, each of 5 store reads, a decode step and 2 point beats;
// the single store read port reads the cabin bytes one at a time.
// rx is not ready while a packet is decoded; a stalled points beat holds the sequence.
// arst_n clears the framing count, the running XOR and the sequencer.
`timescale 1ns / 1ps
`default_nettype none
module lidar_express_packet_decoder_top (
	input  wire logic    clk,
	input  wire logic    arst_n,
	lepd_byte_if.sink    rx,
	lepd_point_if.source points
);
	import lepd_pkg::*;

	lepd_cmd_t cmd;
	lepd_sts_t sts;
	point_t    result;

	lepd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (rx.valid),
		.in_ready  (rx.ready),
		.out_valid (points.valid),
		.out_ready (points.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	lepd_dpath u_dpath (
		.clk     (clk),
		.arst_n  (arst_n),
		.rx_byte (rx.rx_byte),
		.cmd     (cmd),
		.sts     (sts),
		.result  (result)
	);

	assign points.angle_q6    = result.angle_q6;
	assign points.distance_q2 = result.distance_q2;
	assign points.scan_start  = result.scan_start;
	assign points.status      = result.status;
	assign points.last        = result.last;

endmodule
`default_nettype wire
